// ===== rtl/ccfa_pkg.sv =====
// Shared identifiers, result kinds and controller/datapath handshake types.
`timescale 1ns / 1ps
package ccfa_pkg;

	localparam logic [10:0] ID_TOTALS = 11'h400;
	localparam logic [10:0] ID_OUTPUT = 11'h401;
	localparam logic [10:0] ID_SENSOR = 11'h402;
	localparam logic [10:0] ID_DIM    = 11'h403;
	localparam logic [10:0] ID_RESET  = 11'h404;

	localparam logic [1:0] KIND_ECHO   = 2'd0;
	localparam logic [1:0] KIND_OUTPUT = 2'd1;
	localparam logic [1:0] KIND_SENSOR = 2'd2;
	localparam logic [1:0] KIND_DIM    = 2'd3;

	localparam logic [3:0] DLC_MAX       = 4'd8;
	localparam logic [3:0] DLC_MIN_TOTAL = 4'd3;
	localparam logic [3:0] DLC_MIN_ITEM  = 4'd2;

	typedef struct packed {
		logic take;
		logic emit;
	} ccfa_cmd_t;

	typedef struct packed {
		logic out_free;
		logic dump_req;
		logic dump_last;
	} ccfa_sts_t;

endpackage

// ===== rtl/ccfa_ctrl.sv =====
// Controller: accepts frames and sequences the table dump.
`timescale 1ns / 1ps
module ccfa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rx_valid,
	output logic                rx_stall,
	input  ccfa_pkg::ccfa_sts_t sts,
	output ccfa_pkg::ccfa_cmd_t cmd
);
	import ccfa_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DUMP = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		cmd.take = (state_q == ST_IDLE) && rx_valid && sts.out_free;
		cmd.emit = (state_q == ST_DUMP) && sts.out_free;
		rx_stall = (state_q != ST_IDLE) || !sts.out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.take && sts.dump_req) begin
					state_d = ST_DUMP;
				end
			end
			ST_DUMP: begin
				if (cmd.emit && sts.dump_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/ccfa_dp.sv =====
// Datapath: totals, value tables, dump counter and the output word register.
`timescale 1ns / 1ps
module ccfa_dp #(
	parameter int MAX_OUTPUT_ITEMS = 16,
	parameter int MAX_SENSOR_ITEMS = 5,
	parameter int MAX_DIM_ITEMS    = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ccfa_pkg::ccfa_cmd_t cmd,
	output ccfa_pkg::ccfa_sts_t sts,
	input  logic [10:0]         frame_id,
	input  logic [3:0]          frame_dlc,
	input  logic [7:0]          rx_byte0,
	input  logic [7:0]          rx_byte1,
	input  logic [7:0]          rx_byte2,
	input  logic [7:0]          rx_byte3,
	input  logic [7:0]          rx_byte4,
	input  logic [7:0]          rx_byte5,
	input  logic [7:0]          rx_byte6,
	input  logic [7:0]          rx_byte7,
	output logic                tx_valid,
	input  logic                tx_stall,
	output logic [1:0]          result_kind,
	output logic [10:0]         resp_id,
	output logic [3:0]          resp_dlc,
	output logic [7:0]          echo_byte0,
	output logic [7:0]          echo_byte1,
	output logic [7:0]          echo_byte2,
	output logic [7:0]          echo_byte3,
	output logic [7:0]          echo_byte4,
	output logic [7:0]          echo_byte5,
	output logic [7:0]          echo_byte6,
	output logic [7:0]          echo_byte7,
	output logic                last_of_run
);
	import ccfa_pkg::*;

	localparam int OW = (MAX_OUTPUT_ITEMS > 1) ? $clog2(MAX_OUTPUT_ITEMS) : 1;
	localparam int SW = (MAX_SENSOR_ITEMS > 1) ? $clog2(MAX_SENSOR_ITEMS) : 1;
	localparam int DW = (MAX_DIM_ITEMS > 1) ? $clog2(MAX_DIM_ITEMS) : 1;
	localparam int OTW = $clog2(MAX_OUTPUT_ITEMS + 1);
	localparam int STW = $clog2(MAX_SENSOR_ITEMS + 1);
	localparam int DTW = $clog2(MAX_DIM_ITEMS + 1);
	localparam int MAX_ALL_A = (MAX_OUTPUT_ITEMS > MAX_SENSOR_ITEMS) ?
		MAX_OUTPUT_ITEMS : MAX_SENSOR_ITEMS;
	localparam int MAX_ALL = (MAX_ALL_A > MAX_DIM_ITEMS) ? MAX_ALL_A : MAX_DIM_ITEMS;
	localparam int IW = (MAX_ALL > 1) ? $clog2(MAX_ALL) : 1;

	logic           armed_q;
	logic [OTW-1:0] out_tot_q;
	logic [STW-1:0] sen_tot_q;
	logic [DTW-1:0] dim_tot_q;
	logic [7:0]     out_tab_q [MAX_OUTPUT_ITEMS];
	logic [7:0]     sen_tab_q [MAX_SENSOR_ITEMS];
	logic [7:0]     dim_tab_q [MAX_DIM_ITEMS];
	logic [1:0]     dkind_q;
	logic [IW-1:0]  cnt_q;

	logic           tx_valid_q;
	logic [1:0]     kind_q;
	logic [10:0]    id_q;
	logic [3:0]     dlc_q;
	logic [7:0]     byte_q [8];
	logic           last_q;

	logic [7:0] rx_b [8];
	logic [7:0] echo_b [8];
	logic [3:0] clen;
	logic       id_hit;
	logic       tot_ok;
	logic       item_ok;
	logic       out_wr;
	logic       sen_wr;
	logic       dim_wr;
	logic       dump_end;
	logic       clear;
	logic [7:0] idx_m1;
	logic [7:0] out_clamp;
	logic [7:0] sen_clamp;
	logic [7:0] dim_clamp;
	logic [7:0] ent_val;
	logic [7:0] ent_tot;
	logic       cls_end;

	assign rx_b[0] = rx_byte0;
	assign rx_b[1] = rx_byte1;
	assign rx_b[2] = rx_byte2;
	assign rx_b[3] = rx_byte3;
	assign rx_b[4] = rx_byte4;
	assign rx_b[5] = rx_byte5;
	assign rx_b[6] = rx_byte6;
	assign rx_b[7] = rx_byte7;

	always_comb begin
		clen = (frame_dlc > DLC_MAX) ? DLC_MAX : frame_dlc;
		for (int i = 0; i < 8; i++) begin
			echo_b[i] = (4'(i) < clen) ? rx_b[i] : 8'd0;
		end
	end

	assign id_hit  = (frame_id >= ID_TOTALS) && (frame_id <= ID_RESET);
	assign tot_ok  = cmd.take && (frame_id == ID_TOTALS) && (frame_dlc >= DLC_MIN_TOTAL);
	assign item_ok = cmd.take && armed_q && (frame_dlc >= DLC_MIN_ITEM) && (rx_byte0 != 8'd0);
	assign idx_m1  = rx_byte0 - 8'd1;
	assign out_wr  = item_ok && (frame_id == ID_OUTPUT) && (rx_byte0 <= 8'(out_tot_q));
	assign sen_wr  = item_ok && (frame_id == ID_SENSOR) && (rx_byte0 <= 8'(sen_tot_q));
	assign dim_wr  = item_ok && (frame_id == ID_DIM) && (rx_byte0 <= 8'(dim_tot_q));

	assign out_clamp = (rx_byte0 > 8'(MAX_OUTPUT_ITEMS)) ? 8'(MAX_OUTPUT_ITEMS) : rx_byte0;
	assign sen_clamp = (rx_byte1 > 8'(MAX_SENSOR_ITEMS)) ? 8'(MAX_SENSOR_ITEMS) : rx_byte1;
	assign dim_clamp = (rx_byte2 > 8'(MAX_DIM_ITEMS)) ? 8'(MAX_DIM_ITEMS) : rx_byte2;

	always_comb begin
		case (dkind_q)
			KIND_OUTPUT: begin
				ent_val = out_tab_q[cnt_q[OW-1:0]];
				ent_tot = 8'(out_tot_q);
				cls_end = (cnt_q == IW'(MAX_OUTPUT_ITEMS - 1));
			end
			KIND_SENSOR: begin
				ent_val = sen_tab_q[cnt_q[SW-1:0]];
				ent_tot = 8'(sen_tot_q);
				cls_end = (cnt_q == IW'(MAX_SENSOR_ITEMS - 1));
			end
			default: begin
				ent_val = dim_tab_q[cnt_q[DW-1:0]];
				ent_tot = 8'(dim_tot_q);
				cls_end = (cnt_q == IW'(MAX_DIM_ITEMS - 1));
			end
		endcase
	end

	assign dump_end = cmd.emit && sts.dump_last;
	assign clear    = tot_ok || dump_end;

	always_comb begin
		sts.out_free  = !tx_valid_q || !tx_stall;
		sts.dump_req  = (frame_id == ID_RESET) && armed_q;
		sts.dump_last = (dkind_q == KIND_DIM) && cls_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= 1'b0;
			out_tot_q <= '0;
			sen_tot_q <= '0;
			dim_tot_q <= '0;
			dkind_q   <= KIND_OUTPUT;
			cnt_q     <= '0;
			tx_valid_q <= 1'b0;
			for (int i = 0; i < MAX_OUTPUT_ITEMS; i++) out_tab_q[i] <= 8'd0;
			for (int i = 0; i < MAX_SENSOR_ITEMS; i++) sen_tab_q[i] <= 8'd0;
			for (int i = 0; i < MAX_DIM_ITEMS; i++) dim_tab_q[i] <= 8'd0;
		end else begin
			if (clear) begin
				for (int i = 0; i < MAX_OUTPUT_ITEMS; i++) out_tab_q[i] <= 8'd0;
				for (int i = 0; i < MAX_SENSOR_ITEMS; i++) sen_tab_q[i] <= 8'd0;
				for (int i = 0; i < MAX_DIM_ITEMS; i++) dim_tab_q[i] <= 8'd0;
			end
			if (tot_ok) begin
				armed_q   <= 1'b1;
				out_tot_q <= OTW'(out_clamp);
				sen_tot_q <= STW'(sen_clamp);
				dim_tot_q <= DTW'(dim_clamp);
			end
			if (dump_end) begin
				armed_q   <= 1'b0;
				out_tot_q <= '0;
				sen_tot_q <= '0;
				dim_tot_q <= '0;
			end
			if (out_wr) out_tab_q[idx_m1[OW-1:0]] <= rx_byte1;
			if (sen_wr) sen_tab_q[idx_m1[SW-1:0]] <= rx_byte1;
			if (dim_wr) dim_tab_q[idx_m1[DW-1:0]] <= rx_byte1;

			if (cmd.take && sts.dump_req) begin
				dkind_q <= KIND_OUTPUT;
				cnt_q   <= '0;
			end else if (cmd.emit) begin
				if (cls_end) begin
					dkind_q <= (dkind_q == KIND_OUTPUT) ? KIND_SENSOR : KIND_DIM;
					cnt_q   <= '0;
				end else begin
					cnt_q <= cnt_q + IW'(1);
				end
			end

			if ((cmd.take && id_hit) || cmd.emit) begin
				tx_valid_q <= 1'b1;
			end else if (!tx_stall) begin
				tx_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && id_hit) begin
			kind_q <= KIND_ECHO;
			id_q   <= frame_id;
			dlc_q  <= clen;
			for (int i = 0; i < 8; i++) byte_q[i] <= echo_b[i];
			last_q <= !sts.dump_req;
		end else if (cmd.emit) begin
			kind_q    <= dkind_q;
			id_q      <= ID_RESET;
			dlc_q     <= 4'd0;
			byte_q[0] <= 8'(cnt_q);
			byte_q[1] <= ent_val;
			byte_q[2] <= ent_tot;
			for (int i = 3; i < 8; i++) byte_q[i] <= 8'd0;
			last_q <= sts.dump_last;
		end
	end

	assign tx_valid    = tx_valid_q;
	assign result_kind = kind_q;
	assign resp_id     = id_q;
	assign resp_dlc    = dlc_q;
	assign echo_byte0  = byte_q[0];
	assign echo_byte1  = byte_q[1];
	assign echo_byte2  = byte_q[2];
	assign echo_byte3  = byte_q[3];
	assign echo_byte4  = byte_q[4];
	assign echo_byte5  = byte_q[5];
	assign echo_byte6  = byte_q[6];
	assign echo_byte7  = byte_q[7];
	assign last_of_run = last_q;

endmodule

// ===== rtl/can_config_frame_assembler.sv =====
// Top level of the CAN configuration frame assembler.
// Input channel rx: one received frame per word (frame_id, frame_dlc, rx_byte0..7),
// taken when rx_valid is high and rx_stall is low.
// Output channel tx: one result per word (result_kind, resp_id, resp_dlc,
// echo_byte0..7, last_of_run), taken when tx_valid is high and tx_stall is low.
// Frames 0x400..0x404 give an echo word in the cycle after acceptance; other
// identifiers are taken and give nothing.
// An armed reset command gives the echo followed by one dump word per table
// entry, one per cycle from the output register while tx is not stalled, so
// MAX_OUTPUT_ITEMS + MAX_SENSOR_ITEMS + MAX_DIM_ITEMS + 1 words (26 by default);
// the dump sequencer holds rx_stall high until the last word is loaded.
// For any other frame, a new frame is taken while the previous result still
// sits in the output register if tx is not stalled.
// A stalled tx word holds, and rx_stall rises until the register frees up.
// Reset clears the totals, tables and armed flag and empties the output register.
`timescale 1ns / 1ps
module can_config_frame_assembler #(
	parameter int MAX_OUTPUT_ITEMS = 16,
	parameter int MAX_SENSOR_ITEMS = 5,
	parameter int MAX_DIM_ITEMS    = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [10:0] frame_id,
	input  logic [3:0]  frame_dlc,
	input  logic [7:0]  rx_byte0,
	input  logic [7:0]  rx_byte1,
	input  logic [7:0]  rx_byte2,
	input  logic [7:0]  rx_byte3,
	input  logic [7:0]  rx_byte4,
	input  logic [7:0]  rx_byte5,
	input  logic [7:0]  rx_byte6,
	input  logic [7:0]  rx_byte7,
	output logic        tx_valid,
	input  logic        tx_stall,
	output logic [1:0]  result_kind,
	output logic [10:0] resp_id,
	output logic [3:0]  resp_dlc,
	output logic [7:0]  echo_byte0,
	output logic [7:0]  echo_byte1,
	output logic [7:0]  echo_byte2,
	output logic [7:0]  echo_byte3,
	output logic [7:0]  echo_byte4,
	output logic [7:0]  echo_byte5,
	output logic [7:0]  echo_byte6,
	output logic [7:0]  echo_byte7,
	output logic        last_of_run
);
	import ccfa_pkg::*;

	ccfa_cmd_t cmd;
	ccfa_sts_t sts;

	ccfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ccfa_dp #(
		.MAX_OUTPUT_ITEMS (MAX_OUTPUT_ITEMS),
		.MAX_SENSOR_ITEMS (MAX_SENSOR_ITEMS),
		.MAX_DIM_ITEMS    (MAX_DIM_ITEMS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.frame_id    (frame_id),
		.frame_dlc   (frame_dlc),
		.rx_byte0    (rx_byte0),
		.rx_byte1    (rx_byte1),
		.rx_byte2    (rx_byte2),
		.rx_byte3    (rx_byte3),
		.rx_byte4    (rx_byte4),
		.rx_byte5    (rx_byte5),
		.rx_byte6    (rx_byte6),
		.rx_byte7    (rx_byte7),
		.tx_valid    (tx_valid),
		.tx_stall    (tx_stall),
		.result_kind (result_kind),
		.resp_id     (resp_id),
		.resp_dlc    (resp_dlc),
		.echo_byte0  (echo_byte0),
		.echo_byte1  (echo_byte1),
		.echo_byte2  (echo_byte2),
		.echo_byte3  (echo_byte3),
		.echo_byte4  (echo_byte4),
		.echo_byte5  (echo_byte5),
		.echo_byte6  (echo_byte6),
		.echo_byte7  (echo_byte7),
		.last_of_run (last_of_run)
	);

endmodule

// ===== rtl/ccfa_chk.sv =====
// Port-level checker for the frame assembler, bound to the top level.
`timescale 1ns / 1ps
module ccfa_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        rx_stall,
	input logic        tx_valid,
	input logic        tx_stall,
	input logic [1:0]  result_kind,
	input logic [10:0] resp_id,
	input logic [3:0]  resp_dlc,
	input logic [7:0]  echo_byte3,
	input logic        last_of_run
);
	import ccfa_pkg::*;

	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_stall |=> tx_valid && $stable(result_kind) && $stable(resp_id)
			&& $stable(echo_byte3) && $stable(last_of_run))
		else $error("stalled tx word changed");

	a_dump_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && (result_kind != KIND_ECHO) |->
			(resp_id == ID_RESET) && (resp_dlc == 4'd0) && (echo_byte3 == 8'd0))
		else $error("dump word has bad header");

	a_echo_dlc: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && (result_kind == KIND_ECHO) |-> (resp_dlc <= DLC_MAX)
			&& (resp_id >= ID_TOTALS) && (resp_id <= ID_RESET))
		else $error("echo word out of range");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && last_of_run |-> (result_kind == KIND_ECHO) || (result_kind == KIND_DIM))
		else $error("run ends on wrong kind");

	a_dump_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && (result_kind != KIND_ECHO) && !last_of_run |-> rx_stall)
		else $error("frame accepted during dump");

endmodule

bind can_config_frame_assembler ccfa_chk u_ccfa_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.rx_stall    (rx_stall),
	.tx_valid    (tx_valid),
	.tx_stall    (tx_stall),
	.result_kind (result_kind),
	.resp_id     (resp_id),
	.resp_dlc    (resp_dlc),
	.echo_byte3  (echo_byte3),
	.last_of_run (last_of_run)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for the CAN frame assembler: random frames, predicted echoes and dumps.
`timescale 1ns / 1ps
module tb_top;
	import ccfa_pkg::*;

	localparam int N_OUT = 16;
	localparam int N_SEN = 5;
	localparam int N_DIM = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [10:0]     id;
		logic [3:0]      dlc;
		logic [7:0][7:0] data;
	} can_frame_t;

	typedef struct packed {
		logic [1:0]      kind;
		logic [10:0]     id;
		logic [3:0]      dlc;
		logic [7:0][7:0] data;
		logic            last;
	} can_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rx_valid = 1'b0;
	logic tx_stall = 1'b0;
	can_frame_t drv_frame = '0;

	logic        rx_stall;
	logic        tx_valid;
	logic [1:0]  result_kind;
	logic [10:0] resp_id;
	logic [3:0]  resp_dlc;
	logic [7:0]  echo_byte0, echo_byte1, echo_byte2, echo_byte3;
	logic [7:0]  echo_byte4, echo_byte5, echo_byte6, echo_byte7;
	logic        last_of_run;

	can_frame_t  frame_q[$];
	can_result_t resp_q[$];

	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int frames_sent = 0;
	int frames_taken = 0;
	int results_checked = 0;
	int dumps_predicted = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	// predicted block state
	logic       pr_armed;
	logic [4:0] pr_out_total;
	logic [2:0] pr_sen_total;
	logic [2:0] pr_dim_total;
	logic [7:0] pr_out_tbl[N_OUT];
	logic [7:0] pr_sen_tbl[N_SEN];
	logic [7:0] pr_dim_tbl[N_DIM];
	logic [N_OUT-1:0] pr_out_mask;
	logic [N_SEN-1:0] pr_sen_mask;
	logic [N_DIM-1:0] pr_dim_mask;

	logic [10:0] frame_id;
	logic [3:0]  frame_dlc;

	assign {frame_id, frame_dlc} = {drv_frame.id, drv_frame.dlc};

	can_config_frame_assembler #(
		.MAX_OUTPUT_ITEMS(N_OUT),
		.MAX_SENSOR_ITEMS(N_SEN),
		.MAX_DIM_ITEMS(N_DIM)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.rx_valid(rx_valid),
		.rx_stall(rx_stall),
		.frame_id(frame_id),
		.frame_dlc(frame_dlc),
		.rx_byte0(drv_frame.data[0]),
		.rx_byte1(drv_frame.data[1]),
		.rx_byte2(drv_frame.data[2]),
		.rx_byte3(drv_frame.data[3]),
		.rx_byte4(drv_frame.data[4]),
		.rx_byte5(drv_frame.data[5]),
		.rx_byte6(drv_frame.data[6]),
		.rx_byte7(drv_frame.data[7]),
		.tx_valid(tx_valid),
		.tx_stall(tx_stall),
		.result_kind(result_kind),
		.resp_id(resp_id),
		.resp_dlc(resp_dlc),
		.echo_byte0(echo_byte0),
		.echo_byte1(echo_byte1),
		.echo_byte2(echo_byte2),
		.echo_byte3(echo_byte3),
		.echo_byte4(echo_byte4),
		.echo_byte5(echo_byte5),
		.echo_byte6(echo_byte6),
		.echo_byte7(echo_byte7),
		.last_of_run(last_of_run)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic can_frame_t mk_frame(logic [10:0] id, logic [3:0] dlc,
		logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
		can_frame_t f;
		f.id = id;
		f.dlc = dlc;
		for (int i = 0; i < 8; i++)
			f.data[i] = 8'($urandom);
		f.data[0] = b0;
		f.data[1] = b1;
		f.data[2] = b2;
		return f;
	endfunction

	task automatic clear_config_state();
		pr_armed = 1'b0;
		pr_out_total = '0;
		pr_sen_total = '0;
		pr_dim_total = '0;
		pr_out_mask = '0;
		pr_sen_mask = '0;
		pr_dim_mask = '0;
		foreach (pr_out_tbl[i]) pr_out_tbl[i] = '0;
		foreach (pr_sen_tbl[i]) pr_sen_tbl[i] = '0;
		foreach (pr_dim_tbl[i]) pr_dim_tbl[i] = '0;
	endtask

	task automatic push_dump_entry(logic [1:0] kind, int idx, logic [7:0] val,
		logic [7:0] total, logic last);
		can_result_t r;
		r = '0;
		r.kind = kind;
		r.id = ID_RESET;
		r.data[0] = 8'(idx);
		r.data[1] = val;
		r.data[2] = total;
		r.last = last;
		resp_q.push_back(r);
	endtask

	task automatic predict_frame(can_frame_t f);
		can_result_t r;
		logic [3:0] clen;
		logic [7:0] idx;
		logic dump;
		if (f.id < ID_TOTALS || f.id > ID_RESET)
			return;
		clen = (f.dlc > DLC_MAX) ? DLC_MAX : f.dlc;
		dump = (f.id == ID_RESET) && pr_armed;
		r = '0;
		r.kind = KIND_ECHO;
		r.id = f.id;
		r.dlc = clen;
		for (int i = 0; i < 8; i++)
			r.data[i] = (i < clen) ? f.data[i] : 8'h00;
		r.last = !dump;
		resp_q.push_back(r);
		idx = f.data[0];
		case (f.id)
			ID_TOTALS: begin
				if (f.dlc >= DLC_MIN_TOTAL) begin
					clear_config_state();
					pr_out_total = (f.data[0] > N_OUT) ? 5'(N_OUT) : f.data[0][4:0];
					pr_sen_total = (f.data[1] > N_SEN) ? 3'(N_SEN) : f.data[1][2:0];
					pr_dim_total = (f.data[2] > N_DIM) ? 3'(N_DIM) : f.data[2][2:0];
					pr_armed = 1'b1;
				end
			end
			ID_OUTPUT: begin
				if (pr_armed && f.dlc >= DLC_MIN_ITEM && idx >= 1 && idx <= pr_out_total) begin
					pr_out_tbl[idx - 1] = f.data[1];
					pr_out_mask[idx - 1] = 1'b1;
				end
			end
			ID_SENSOR: begin
				if (pr_armed && f.dlc >= DLC_MIN_ITEM && idx >= 1 && idx <= pr_sen_total) begin
					pr_sen_tbl[idx - 1] = f.data[1];
					pr_sen_mask[idx - 1] = 1'b1;
				end
			end
			ID_DIM: begin
				if (pr_armed && f.dlc >= DLC_MIN_ITEM && idx >= 1 && idx <= pr_dim_total) begin
					pr_dim_tbl[idx - 1] = f.data[1];
					pr_dim_mask[idx - 1] = 1'b1;
				end
			end
			default: begin
				if (dump) begin
					for (int i = 0; i < N_OUT; i++)
						push_dump_entry(KIND_OUTPUT, i, pr_out_tbl[i], 8'(pr_out_total), 1'b0);
					for (int i = 0; i < N_SEN; i++)
						push_dump_entry(KIND_SENSOR, i, pr_sen_tbl[i], 8'(pr_sen_total), 1'b0);
					for (int i = 0; i < N_DIM; i++)
						push_dump_entry(KIND_DIM, i, pr_dim_tbl[i], 8'(pr_dim_total),
							i == N_DIM - 1);
					dumps_predicted++;
					clear_config_state();
				end
			end
		endcase
	endtask

	task automatic note_mismatch(string what, can_result_t exp, can_result_t got);
		if (mismatches < MAX_REPORTS) begin
			$display("%0t: %s: expected kind=%0d id=%h dlc=%0d data=%h last=%b",
				$realtime, what, exp.kind, exp.id, exp.dlc, exp.data, exp.last);
			$display("%0t: %s: got      kind=%0d id=%h dlc=%0d data=%h last=%b",
				$realtime, what, got.kind, got.id, got.dlc, got.data, got.last);
		end
		mismatches++;
	endtask

	// driver: advance on acceptance, hold otherwise
	always @(negedge clk) begin
		if (arst_n && frames_taken == frames_sent) begin
			if (frame_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				drv_frame <= frame_q.pop_front();
				rx_valid <= 1'b1;
				frames_sent++;
			end else begin
				rx_valid <= 1'b0;
			end
		end
		tx_stall <= arst_n && ($urandom_range(0, 99) < sink_stall_pct);
	end

	// monitor: predict on accepted frames, check accepted results
	always @(posedge clk) begin
		can_result_t got;
		can_result_t exp;
		logic bad;
		if (arst_n) begin
			quiet_cycles++;
			if (rx_valid && !rx_stall) begin
				predict_frame(drv_frame);
				frames_taken++;
				quiet_cycles = 0;
			end
			if (tx_valid && !tx_stall) begin
				quiet_cycles = 0;
				got.kind = result_kind;
				got.id = resp_id;
				got.dlc = resp_dlc;
				got.data = {echo_byte7, echo_byte6, echo_byte5, echo_byte4,
					echo_byte3, echo_byte2, echo_byte1, echo_byte0};
				got.last = last_of_run;
				if (resp_q.size() == 0) begin
					note_mismatch("unexpected result", '0, got);
				end else begin
					exp = resp_q.pop_front();
					bad = (got.kind !== exp.kind) || (got.id !== exp.id) ||
						(got.dlc !== exp.dlc) || (got.last !== exp.last);
					for (int i = 0; i < 8; i++)
						bad = bad || (got.data[i] !== exp.data[i]);
					if (bad)
						note_mismatch("result mismatch", exp, got);
				end
				results_checked++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d results outstanding",
					$realtime, quiet_cycles, resp_q.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic run_phase(int src_pct, int sink_pct, int n_items);
		int made;
		int ot;
		int st;
		int dt;
		int k;
		int cls;
		int tot;
		logic [10:0] id;
		logic [7:0] idx;
		logic [3:0] dlc;
		src_idle_pct = src_pct;
		sink_stall_pct = sink_pct;
		made = 0;
		while (made < n_items) begin
			if ($urandom_range(0, 9) < 7) begin
				ot = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 18);
				st = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
				dt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
				frame_q.push_back(mk_frame(ID_TOTALS, 4'($urandom_range(3, 15)),
					8'(ot), 8'(st), 8'(dt)));
				ot = (ot > N_OUT) ? N_OUT : ot;
				st = (st > N_SEN) ? N_SEN : st;
				dt = (dt > N_DIM) ? N_DIM : dt;
				k = $urandom_range(0, 14);
				repeat (k) begin
					cls = $urandom_range(0, 2);
					tot = (cls == 0) ? ot : (cls == 1) ? st : dt;
					id = ID_OUTPUT + 11'(cls);
					idx = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
						8'($urandom_range(1, (tot > 0) ? tot : 1));
					dlc = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 1)) :
						4'($urandom_range(2, 15));
					frame_q.push_back(mk_frame(id, dlc, idx, 8'($urandom), 8'($urandom)));
				end
				frame_q.push_back(mk_frame(ID_RESET, 4'($urandom_range(0, 15)),
					8'($urandom), 8'($urandom), 8'($urandom)));
				made += k + 2;
			end else begin
				id = $urandom_range(0, 1) ? 11'($urandom_range(0, 2047)) :
					ID_TOTALS + 11'($urandom_range(0, 4));
				frame_q.push_back(mk_frame(id, 4'($urandom_range(0, 15)),
					8'($urandom), 8'($urandom), 8'($urandom)));
				if (id >= ID_TOTALS && id <= ID_RESET)
					made++;
			end
		end
		while (frame_q.size() != 0 || frames_taken != frames_sent)
			@(posedge clk);
	endtask

	initial begin
		can_frame_t f;
		clear_config_state();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// unrelated identifiers at and around the window
		frame_q.push_back(mk_frame(11'h000, 4'd8, 8'h00, 8'h00, 8'h00));
		frame_q.push_back(mk_frame(11'h7FF, 4'd15, 8'hFF, 8'hFF, 8'hFF));
		frame_q.push_back(mk_frame(ID_TOTALS - 11'd1, 4'd3, 8'd4, 8'd2, 8'd1));
		frame_q.push_back(mk_frame(ID_RESET + 11'd1, 4'd3, 8'd4, 8'd2, 8'd1));
		// not armed: reset command and item are echoed only
		frame_q.push_back(mk_frame(ID_RESET, 4'd0, 8'h00, 8'h00, 8'h00));
		frame_q.push_back(mk_frame(ID_OUTPUT, 4'd2, 8'd1, 8'hAA, 8'h00));
		// short totals frame
		frame_q.push_back(mk_frame(ID_TOTALS, 4'd2, 8'd3, 8'd3, 8'd3));
		// totals above maximum clamp
		f = mk_frame(ID_TOTALS, 4'd8, 8'hFF, 8'hFF, 8'hFF);
		f.data = {8{8'hFF}};
		frame_q.push_back(f);
		frame_q.push_back(mk_frame(ID_OUTPUT, 4'd2, 8'd0, 8'h11, 8'h00));
		frame_q.push_back(mk_frame(ID_OUTPUT, 4'd2, 8'd16, 8'hFF, 8'h00));
		frame_q.push_back(mk_frame(ID_OUTPUT, 4'd8, 8'd17, 8'h22, 8'h00));
		frame_q.push_back(mk_frame(ID_OUTPUT, 4'd3, 8'd1, 8'h00, 8'h00));
		frame_q.push_back(mk_frame(ID_SENSOR, 4'd15, 8'd5, 8'h5A, 8'h00));
		frame_q.push_back(mk_frame(ID_SENSOR, 4'd1, 8'd1, 8'h33, 8'h00));
		frame_q.push_back(mk_frame(ID_DIM, 4'd2, 8'd4, 8'hA5, 8'h00));
		frame_q.push_back(mk_frame(ID_DIM, 4'd2, 8'd5, 8'h44, 8'h00));
		frame_q.push_back(mk_frame(ID_RESET, 4'd9, 8'h00, 8'hFF, 8'h00));
		// totals of zero: every item falls outside its class
		f = mk_frame(ID_TOTALS, 4'd8, 8'h00, 8'h00, 8'h00);
		f.data = '0;
		frame_q.push_back(f);
		frame_q.push_back(mk_frame(ID_OUTPUT, 4'd2, 8'd1, 8'h77, 8'h00));
		frame_q.push_back(mk_frame(ID_RESET, 4'd1, 8'h00, 8'h00, 8'h00));
		// small totals, partly filled, then dump
		frame_q.push_back(mk_frame(ID_TOTALS, 4'd3, 8'd3, 8'd2, 8'd1));
		frame_q.push_back(mk_frame(ID_OUTPUT, 4'd2, 8'd3, 8'h80, 8'h00));
		frame_q.push_back(mk_frame(ID_DIM, 4'd2, 8'd1, 8'h01, 8'h00));
		frame_q.push_back(mk_frame(ID_RESET, 4'd4, 8'h00, 8'h00, 8'h00));
		while (frame_q.size() != 0 || frames_taken != frames_sent)
			@(posedge clk);

		run_phase(0, 0, 125);
		run_phase(62, 0, 125);
		run_phase(0, 62, 125);
		run_phase(34, 34, 125);

		src_idle_pct = 0;
		sink_stall_pct = 0;
		while (resp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d frames over four idling phases, %0d results, %0d dumps.",
			frames_taken, results_checked, dumps_predicted);
		$display("Mismatching results: %0d.", mismatches);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
